// ----- rtl/sci_pkg.sv -----
// Shared types and constants for the sphere collision impulse block.
package sci_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned ELAST_W        = 15;
  localparam int unsigned FORCE_W        = 48;
  localparam int unsigned FMAG_W         = 47;
  localparam int unsigned K_W            = 17;
  localparam int unsigned K_ONE          = 32768;
  localparam int unsigned JMAG_W         = 63;
  localparam int unsigned FRAC_W         = 16;
  localparam int unsigned NN_SHIFT       = 15;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned OUT_USER_W     = 3;

  typedef enum logic [1:0] {
    OP_FIRST  = 2'd0,
    OP_SECOND = 2'd1,
    OP_PLANE  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DEGEN   = 2'd1,
    ST_NOFIRST = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NN,
    S_DOT,
    S_MU_MUL,
    S_MU_DIV,
    S_Q_MUL1,
    S_Q_MUL2,
    S_Q_DIV,
    S_F_MUL,
    S_OUT_A,
    S_OUT_B
  } state_e;

  typedef struct packed {
    logic start;
    logic div;
  } cmd_t;

endpackage

// ----- rtl/sci_muldiv.sv -----
// Shared iterative unit: shift-add multiplier and restoring divider.
module sci_muldiv #(
  parameter int unsigned PW = 116,
  parameter int unsigned BW = 82
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sci_pkg::cmd_t cmd_i,
  input  logic [PW-1:0] opa_i,
  input  logic [BW-1:0] opb_i,
  output logic          done_o,
  output logic [PW-1:0] res_o
);

  localparam int unsigned CW = $clog2(PW + 1);

  logic          busy_q, busy_d;
  logic          div_q, div_d;
  logic [PW-1:0] a_q, a_d;
  logic [BW-1:0] b_q, b_d;
  logic [PW-1:0] acc_q, acc_d;
  logic [BW-1:0] r_q, r_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [BW:0]   r2, rsub;
  logic          ge;

  assign r2     = {r_q, a_q[PW-1]};
  assign ge     = r2 >= {1'b0, b_q};
  assign rsub   = r2 - {1'b0, b_q};
  assign done_o = busy_q && (div_q ? (cnt_q == '0) : (b_q == '0));
  assign res_o  = acc_q;

  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      div_d  = cmd_i.div;
      a_d    = opa_i;
      b_d    = opb_i;
      acc_d  = '0;
      r_d    = '0;
      cnt_d  = CW'(PW);
    end else if (busy_q) begin
      if (done_o) begin
        busy_d = 1'b0;
      end else if (div_q) begin
        r_d   = ge ? rsub[BW-1:0] : r2[BW-1:0];
        acc_d = {acc_q[PW-2:0], ge};
        a_d   = {a_q[PW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
      end else begin
        if (b_q[0]) begin
          acc_d = acc_q + a_q;
        end
        a_d = {a_q[PW-2:0], 1'b0};
        b_d = {1'b0, b_q[BW-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    r_q   <= r_d;
    cnt_q <= cnt_d;
  end

endmodule

// ----- rtl/sphere_collision_impulse.sv -----
// Sphere collision impulse unit, top level.
// Input stream: one body per transaction (op, velocity, position, mass,
// elasticity). op 0 stores sphere A, op 1 is sphere B and produces two
// force transactions (body A, tlast low, then body B, tlast high; one if
// no A is stored), op 2 (sphere against plane) produces one, op 3 is dropped.
// Output stream: force x/y/z in Q32.16, tuser carries target body and status.
// s_axis_tready_o is high only while the sequencer is idle; one item is
// worked at a time on a single shift-add multiplier / restoring divider.
// Work per item: a pair runs twelve multiplies and two divides on the
// PW-bit unit (PW = max(3*DATA_WIDTH+20, DATA_WIDTH+64)); a plane item
// runs three multiplies. A stored sphere update does not leave idle.
// A one-entry output register holds the result; while the receiver stalls
// the sequencer waits before loading the next result.
// Reset clears the stored-sphere valid flag, the sequencer and the output valid.
module sphere_collision_impulse #(
  parameter int unsigned DATA_WIDTH = sci_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // op, vel_x, vel_y, vel_z, pos_x, pos_y, pos_z, mass, elasticity, zero pad
  input  logic [((7*DATA_WIDTH+24)/8)*8-1:0] s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // force_x, force_y, force_z
  output logic [3*sci_pkg::FORCE_W-1:0] m_axis_tdata_o,
  // target_body, status
  output logic [sci_pkg::OUT_USER_W-1:0] m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned NW  = W + 1;
  localparam int unsigned NNW = 2 * W + 2;
  localparam int unsigned PWA = 3 * W + 20;
  localparam int unsigned PWB = W + 64;
  localparam int unsigned PW  = (PWA > PWB) ? PWA : PWB;
  localparam int unsigned BWA = NNW + sci_pkg::NN_SHIFT;
  localparam int unsigned BW  = (BWA > 64) ? BWA : 64;
  localparam int unsigned SW  = sci_pkg::JMAG_W;
  localparam int unsigned FM  = sci_pkg::FMAG_W;
  localparam int unsigned FR  = sci_pkg::FRAC_W;
  localparam int unsigned EW  = sci_pkg::ELAST_W;
  localparam int unsigned KW  = sci_pkg::K_W;

  function automatic logic [sci_pkg::FORCE_W-1:0] fsigned(input logic [FM-1:0] mag,
                                                          input logic neg);
    logic [sci_pkg::FORCE_W-1:0] v;
    v = {1'b0, mag};
    return neg ? -v : v;
  endfunction

  sci_pkg::state_e state_q, state_d;
  sci_pkg::status_e st_q, st_d;
  sci_pkg::op_e    in_op;
  sci_pkg::cmd_t   cmd;

  logic signed [W-1:0] in_vel [3];
  logic signed [W-1:0] in_pos [3];
  logic [W-1:0]  in_mass;
  logic [EW-1:0] in_el;
  logic          s_acc, out_free, done, degen, dot_pos;
  logic [PW-1:0] opa, res;
  logic [BW-1:0] opb;
  logic [NNW-1:0] dot;

  logic signed [W-1:0] fv_q [3], fv_d [3];
  logic signed [W-1:0] fp_q [3], fp_d [3];
  logic [W-1:0]  fm_q, fm_d, mb_q, mb_d, mu_q, mu_d;
  logic [EW-1:0] fe_q, fe_d;
  logic          fvalid_q, fvalid_d;
  logic [NW-1:0] nabs_q [3], nabs_d [3], dvabs_q [3], dvabs_d [3];
  logic          nneg_q [3], nneg_d [3], dvneg_q [3], dvneg_d [3];
  logic          sa_q [3], sa_d [3];
  logic [FM-1:0] mag_q [3], mag_d [3];
  logic [NNW-1:0] nn_q, nn_d, dpos_q, dpos_d, dneg_q, dneg_d;
  logic [KW-1:0] k_q, k_d;
  logic [PW-1:0] tmp_q, tmp_d;
  logic [SW-1:0] s_q, s_d;
  logic          single_q, single_d, issued_q, issued_d;
  logic [1:0]    idx_q, idx_d;
  logic          ov_q, ov_d, olast_q, olast_d;
  logic [3*sci_pkg::FORCE_W-1:0] odata_q, odata_d;
  logic [sci_pkg::OUT_USER_W-1:0] ouser_q, ouser_d;

  assign in_op   = sci_pkg::op_e'(s_axis_tdata_i[sci_pkg::OP_W-1:0]);
  assign in_mass = s_axis_tdata_i[2+6*W +: W];
  assign in_el   = s_axis_tdata_i[2+7*W +: EW];
  for (genvar g = 0; g < 3; g++) begin : g_unpack
    assign in_vel[g] = s_axis_tdata_i[2+g*W +: W];
    assign in_pos[g] = s_axis_tdata_i[2+(3+g)*W +: W];
  end

  assign s_axis_tready_o = (state_q == sci_pkg::S_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !ov_q || m_axis_tready_i;
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tuser_o  = ouser_q;
  assign m_axis_tlast_o  = olast_q;

  assign degen   = (fm_q == '0) || (mb_q == '0) || (nn_q == '0);
  assign dot_pos = dpos_q > dneg_q;
  assign dot     = dot_pos ? (dpos_q - dneg_q) : (dneg_q - dpos_q);

  sci_muldiv #(.PW(PW), .BW(BW)) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .opa_i  (opa),
    .opb_i  (opb),
    .done_o (done),
    .res_o  (res)
  );

  // operand select and start
  always_comb begin
    opa       = '0;
    opb       = '0;
    cmd.start = 1'b0;
    cmd.div   = 1'b0;
    case (state_q)
      sci_pkg::S_NN: begin
        opa = PW'(nabs_q[idx_q]);
        opb = BW'(nabs_q[idx_q]);
      end
      sci_pkg::S_DOT: begin
        opa = PW'(nabs_q[idx_q]);
        opb = BW'(dvabs_q[idx_q]);
      end
      sci_pkg::S_MU_MUL: begin
        opa = PW'(fm_q);
        opb = BW'(mb_q);
      end
      sci_pkg::S_MU_DIV: begin
        opa     = tmp_q;
        opb     = BW'({1'b0, fm_q} + {1'b0, mb_q});
        cmd.div = 1'b1;
      end
      sci_pkg::S_Q_MUL1: begin
        opa = PW'(dot);
        opb = BW'(k_q);
      end
      sci_pkg::S_Q_MUL2: begin
        opa = tmp_q;
        opb = BW'(mu_q);
      end
      sci_pkg::S_Q_DIV: begin
        opa     = tmp_q;
        opb     = BW'({nn_q, {sci_pkg::NN_SHIFT{1'b0}}});
        cmd.div = 1'b1;
      end
      sci_pkg::S_F_MUL: begin
        opa = PW'(s_q);
        opb = BW'(nabs_q[idx_q]);
      end
      default: begin
      end
    endcase
    cmd.start = !issued_q && (state_q inside {sci_pkg::S_NN, sci_pkg::S_DOT,
                sci_pkg::S_MU_MUL, sci_pkg::S_MU_DIV, sci_pkg::S_Q_MUL1,
                sci_pkg::S_Q_MUL2, sci_pkg::S_Q_DIV, sci_pkg::S_F_MUL});
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sci_pkg::S_IDLE: begin
        if (s_acc) begin
          case (in_op)
            sci_pkg::OP_SECOND: state_d = fvalid_q ? sci_pkg::S_NN : sci_pkg::S_OUT_A;
            sci_pkg::OP_PLANE:  state_d = sci_pkg::S_F_MUL;
            default:            state_d = sci_pkg::S_IDLE;
          endcase
        end
      end
      sci_pkg::S_NN:     if (done && idx_q == 2'd2) state_d = sci_pkg::S_DOT;
      sci_pkg::S_DOT: begin
        if (done && idx_q == 2'd2) state_d = degen ? sci_pkg::S_OUT_A : sci_pkg::S_MU_MUL;
      end
      sci_pkg::S_MU_MUL: if (done) state_d = sci_pkg::S_MU_DIV;
      sci_pkg::S_MU_DIV: if (done) state_d = sci_pkg::S_Q_MUL1;
      sci_pkg::S_Q_MUL1: if (done) state_d = sci_pkg::S_Q_MUL2;
      sci_pkg::S_Q_MUL2: if (done) state_d = sci_pkg::S_Q_DIV;
      sci_pkg::S_Q_DIV:  if (done) state_d = sci_pkg::S_F_MUL;
      sci_pkg::S_F_MUL:  if (done && idx_q == 2'd2) state_d = sci_pkg::S_OUT_A;
      sci_pkg::S_OUT_A: begin
        if (out_free) state_d = single_q ? sci_pkg::S_IDLE : sci_pkg::S_OUT_B;
      end
      sci_pkg::S_OUT_B:  if (out_free) state_d = sci_pkg::S_IDLE;
      default:           state_d = sci_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    logic [NW-1:0] nf, df;
    fm_d = fm_q; mb_d = mb_q; mu_d = mu_q; fe_d = fe_q; fvalid_d = fvalid_q;
    nn_d = nn_q; dpos_d = dpos_q; dneg_d = dneg_q; k_d = k_q; tmp_d = tmp_q;
    s_d = s_q; st_d = st_q; single_d = single_q;
    ov_d = ov_q; olast_d = olast_q; odata_d = odata_q; ouser_d = ouser_q;
    issued_d = cmd.start ? 1'b1 : (done ? 1'b0 : issued_q);
    idx_d = idx_q;
    for (int i = 0; i < 3; i++) begin
      fv_d[i] = fv_q[i]; fp_d[i] = fp_q[i];
      nabs_d[i] = nabs_q[i]; nneg_d[i] = nneg_q[i];
      dvabs_d[i] = dvabs_q[i]; dvneg_d[i] = dvneg_q[i];
      sa_d[i] = sa_q[i]; mag_d[i] = mag_q[i];
    end
    if (done && (state_q inside {sci_pkg::S_NN, sci_pkg::S_DOT, sci_pkg::S_F_MUL})) begin
      idx_d = (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
    end
    if (ov_q && m_axis_tready_i) begin
      ov_d = 1'b0;
    end
    case (state_q)
      sci_pkg::S_IDLE: begin
        idx_d = 2'd0;
        if (s_acc) begin
          case (in_op)
            sci_pkg::OP_FIRST: begin
              for (int i = 0; i < 3; i++) begin
                fv_d[i] = in_vel[i];
                fp_d[i] = in_pos[i];
              end
              fm_d     = in_mass;
              fe_d     = in_el;
              fvalid_d = 1'b1;
            end
            sci_pkg::OP_SECOND: begin
              if (fvalid_q) begin
                fvalid_d = 1'b0;
                for (int i = 0; i < 3; i++) begin
                  nf = {fp_q[i][W-1], fp_q[i]} - {in_pos[i][W-1], in_pos[i]};
                  df = {fv_q[i][W-1], fv_q[i]} - {in_vel[i][W-1], in_vel[i]};
                  nneg_d[i]  = nf[NW-1];
                  nabs_d[i]  = nf[NW-1] ? -nf : nf;
                  dvneg_d[i] = df[NW-1];
                  dvabs_d[i] = df[NW-1] ? -df : df;
                end
                mb_d     = in_mass;
                k_d      = KW'(sci_pkg::K_ONE) + KW'(fe_q) + KW'(in_el);
                nn_d     = '0;
                dpos_d   = '0;
                dneg_d   = '0;
                st_d     = sci_pkg::ST_OK;
                single_d = 1'b0;
              end else begin
                for (int i = 0; i < 3; i++) begin
                  mag_d[i] = '0;
                  sa_d[i]  = 1'b0;
                end
                st_d     = sci_pkg::ST_NOFIRST;
                single_d = 1'b1;
              end
            end
            sci_pkg::OP_PLANE: begin
              for (int i = 0; i < 3; i++) begin
                nf        = {in_vel[i][W-1], in_vel[i]};
                nabs_d[i] = nf[NW-1] ? -nf : nf;
                sa_d[i]   = !in_vel[i][W-1] && (in_vel[i] != '0);
              end
              s_d      = SW'(in_mass);
              st_d     = (in_mass == '0) ? sci_pkg::ST_DEGEN : sci_pkg::ST_OK;
              single_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      sci_pkg::S_NN: if (done) nn_d = nn_q + res[NNW-1:0];
      sci_pkg::S_DOT: begin
        if (done) begin
          if (nneg_q[idx_q] ^ dvneg_q[idx_q]) dneg_d = dneg_q + res[NNW-1:0];
          else dpos_d = dpos_q + res[NNW-1:0];
          if (idx_q == 2'd2 && degen) begin
            for (int i = 0; i < 3; i++) begin
              mag_d[i] = '0;
              sa_d[i]  = 1'b0;
            end
            st_d = sci_pkg::ST_DEGEN;
          end
        end
      end
      sci_pkg::S_MU_MUL: if (done) tmp_d = res;
      sci_pkg::S_MU_DIV: if (done) mu_d = res[W-1:0];
      sci_pkg::S_Q_MUL1: if (done) tmp_d = res;
      sci_pkg::S_Q_MUL2: if (done) tmp_d = res;
      sci_pkg::S_Q_DIV: begin
        if (done) begin
          s_d = (res[PW-1:SW] != '0) ? {SW{1'b1}} : res[SW-1:0];
          for (int i = 0; i < 3; i++) begin
            sa_d[i] = nneg_q[i] ^ dot_pos;
          end
        end
      end
      sci_pkg::S_F_MUL: begin
        if (done) begin
          mag_d[idx_q] = (res[PW-1:FR+FM] != '0) ? {FM{1'b1}} : res[FR+FM-1:FR];
        end
      end
      sci_pkg::S_OUT_A: begin
        if (out_free) begin
          ov_d    = 1'b1;
          odata_d = {fsigned(mag_q[2], sa_q[2]), fsigned(mag_q[1], sa_q[1]),
                     fsigned(mag_q[0], sa_q[0])};
          ouser_d = {st_q, 1'b0};
          olast_d = single_q;
        end
      end
      sci_pkg::S_OUT_B: begin
        if (out_free) begin
          ov_d    = 1'b1;
          odata_d = {fsigned(mag_q[2], !sa_q[2]), fsigned(mag_q[1], !sa_q[1]),
                     fsigned(mag_q[0], !sa_q[0])};
          ouser_d = {st_q, 1'b1};
          olast_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sci_pkg::S_IDLE;
      fvalid_q <= 1'b0;
      issued_q <= 1'b0;
      idx_q    <= 2'd0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      fvalid_q <= fvalid_d;
      issued_q <= issued_d;
      idx_q    <= idx_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fm_q <= fm_d; mb_q <= mb_d; mu_q <= mu_d; fe_q <= fe_d;
    nn_q <= nn_d; dpos_q <= dpos_d; dneg_q <= dneg_d; k_q <= k_d;
    tmp_q <= tmp_d; s_q <= s_d; st_q <= st_d; single_q <= single_d;
    olast_q <= olast_d; odata_q <= odata_d; ouser_q <= ouser_d;
    for (int i = 0; i < 3; i++) begin
      fv_q[i] <= fv_d[i]; fp_q[i] <= fp_d[i];
      nabs_q[i] <= nabs_d[i]; nneg_q[i] <= nneg_d[i];
      dvabs_q[i] <= dvabs_d[i]; dvneg_q[i] <= dvneg_d[i];
      sa_q[i] <= sa_d[i]; mag_q[i] <= mag_d[i];
    end
  end

endmodule

// ----- rtl/sci_checker.sv -----
// Port-level checker for the sphere collision impulse block, with bind.
module sci_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 m_axis_tvalid_o,
  input logic                                 m_axis_tready_i,
  input logic [3*sci_pkg::FORCE_W-1:0]        m_axis_tdata_o,
  input logic [sci_pkg::OUT_USER_W-1:0]       m_axis_tuser_o,
  input logic                                 m_axis_tlast_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output changed while stalled");

  a_b_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tlast_o)
    else $error("second body transaction without tlast");

  a_nofirst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2:1] == sci_pkg::ST_NOFIRST |->
      m_axis_tlast_o && !m_axis_tuser_o[0] && m_axis_tdata_o == '0)
    else $error("missing-first result malformed");

  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      !m_axis_tvalid_o || m_axis_tuser_o[0])
    else $error("first body transaction not followed by second body");

endmodule

bind sphere_collision_impulse sci_checker u_sci_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
